FILE: rtl/sclt_pkg.sv
// ============================================================================
// sclt_pkg
// Shared types and constants for the command-line tokeniser. This covers
// the item formats, event and token codes, character codes and the queue
// sizing.
// ============================================================================
package sclt_pkg;

    // Line length bound and the saturating position limit derived from it.
    localparam int LINE_LEN = 4096;
    localparam int POS_W = 12;
    localparam int POS_MAX_INT = ((LINE_LEN - 1) < 4095) ? (LINE_LEN - 1) : 4095;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_INT);

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Scanner modes.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_QUOTE = 2'd2,
        MODE_GT    = 2'd3
    } scan_mode_t;

    // Event codes.
    localparam logic [2:0] EV_BYTE     = 3'd0;
    localparam logic [2:0] EV_END      = 3'd1;
    localparam logic [2:0] EV_UNCLOSED = 3'd2;
    localparam logic [2:0] EV_OK       = 3'd3;
    localparam logic [2:0] EV_BAD      = 3'd4;

    // Token types.
    localparam logic [2:0] TT_WORD   = 3'd0;
    localparam logic [2:0] TT_QUOTED = 3'd1;
    localparam logic [2:0] TT_PIPE   = 3'd2;
    localparam logic [2:0] TT_IN     = 3'd3;
    localparam logic [2:0] TT_OUT    = 3'd4;
    localparam logic [2:0] TT_APPEND = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    // Input item: one byte of the line or an end-of-line marker.
    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
    } cmd_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0]       event_res;
        logic [2:0]       token_type;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] position;
        logic             bad_char;
        logic             last;
    } tok_item_t;

    // Results of one input item, handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } lex_wr_t;

endpackage

FILE: rtl/sclt_lexer.sv
// ============================================================================
// sclt_lexer
// Scanner state and byte classification. Produces up to two result items
// for each input item in one pass of combinational logic.
// ============================================================================
module sclt_lexer
    import sclt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cmd_item_t item,
    output lex_wr_t   wr
);

    scan_mode_t       mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] qs_reg, qs_next;
    logic             bad_reg, bad_next;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_allowed(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_DOT) || (c == CH_UNDER) ||
               (c == CH_DASH) || (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_COLON);
    endfunction

    logic [7:0] ch;
    logic       ch_bad;
    logic       ch_term;
    assign ch      = item.char_code;
    assign ch_bad  = ~is_allowed(ch);
    assign ch_term = is_sep(ch) || (ch == CH_QUOTE) || (ch == CH_PIPE) ||
                     (ch == CH_LT) || (ch == CH_GT);

    // Handling of a byte seen between tokens.
    logic       idle_emit;
    tok_item_t  idle_res;
    scan_mode_t idle_mode;
    logic       idle_qs;
    logic       idle_bad;

    always_comb
    begin
        idle_emit = 1'b0;
        idle_res  = '0;
        idle_mode = MODE_IDLE;
        idle_qs   = 1'b0;
        idle_bad  = 1'b0;
        idle_res.position = pos_reg;
        priority if (is_sep(ch))
        begin
            idle_mode = MODE_IDLE;
        end
        else if (ch == CH_QUOTE)
        begin
            idle_mode = MODE_QUOTE;
            idle_qs   = 1'b1;
        end
        else if (ch == CH_PIPE)
        begin
            idle_emit           = 1'b1;
            idle_res.event_res  = EV_END;
            idle_res.token_type = TT_PIPE;
        end
        else if (ch == CH_LT)
        begin
            idle_emit           = 1'b1;
            idle_res.event_res  = EV_END;
            idle_res.token_type = TT_IN;
        end
        else if (ch == CH_GT)
        begin
            idle_mode = MODE_GT;
        end
        else
        begin
            idle_emit           = 1'b1;
            idle_res.event_res  = EV_BYTE;
            idle_res.token_type = TT_WORD;
            idle_res.data_byte  = ch;
            idle_res.bad_char   = ch_bad;
            idle_bad            = ch_bad;
            idle_mode           = MODE_WORD;
        end
    end

    // Results and next state for the current item.
    tok_item_t  r0, r1;
    logic [1:0] n;
    tok_item_t  tok_end;

    always_comb
    begin
        r0        = '0;
        r1        = '0;
        n         = 2'd0;
        tok_end   = '0;
        mode_next = mode_reg;
        qs_next   = qs_reg;
        bad_next  = bad_reg;
        pos_next  = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        r0.position      = pos_reg;
        r1.position      = pos_reg;
        tok_end.position = pos_reg;
        tok_end.event_res = EV_END;

        if (item.operation)
        begin
            // End of line: flag an open quote, or end any token and report status.
            pos_next  = '0;
            qs_next   = '0;
            bad_next  = 1'b0;
            mode_next = MODE_IDLE;
            r1.event_res = bad_reg ? EV_BAD : EV_OK;
            unique case (mode_reg)
                MODE_QUOTE:
                begin
                    r0.event_res = EV_UNCLOSED;
                    r0.position  = qs_reg;
                    n = 2'd1;
                end
                MODE_WORD:
                begin
                    r0 = tok_end;
                    r0.token_type = TT_WORD;
                    n = 2'd2;
                end
                MODE_GT:
                begin
                    r0 = tok_end;
                    r0.token_type = TT_OUT;
                    n = 2'd2;
                end
                default:
                begin
                    r0 = r1;
                    n = 2'd1;
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_WORD:
                begin
                    if (ch_term)
                    begin
                        // The word ends first, then the byte starts afresh.
                        r0 = tok_end;
                        r0.token_type = TT_WORD;
                        r1 = idle_res;
                        n = idle_emit ? 2'd2 : 2'd1;
                        mode_next = idle_mode;
                        if (idle_qs)
                        begin
                            qs_next = pos_reg;
                        end
                    end
                    else
                    begin
                        r0.event_res  = EV_BYTE;
                        r0.token_type = TT_WORD;
                        r0.data_byte  = ch;
                        r0.bad_char   = ch_bad;
                        bad_next      = bad_reg | ch_bad;
                        n = 2'd1;
                    end
                end
                MODE_QUOTE:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        r0 = tok_end;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        r0.event_res = EV_BYTE;
                        r0.data_byte = ch;
                    end
                    r0.token_type = TT_QUOTED;
                    n = 2'd1;
                end
                MODE_GT:
                begin
                    r0 = tok_end;
                    if (ch == CH_GT)
                    begin
                        r0.token_type = TT_APPEND;
                        n = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        // A pending redirect out ends, then the byte starts afresh.
                        r0.token_type = TT_OUT;
                        r1 = idle_res;
                        n = idle_emit ? 2'd2 : 2'd1;
                        mode_next = idle_mode;
                        bad_next  = bad_reg | idle_bad;
                        if (idle_qs)
                        begin
                            qs_next = pos_reg;
                        end
                    end
                end
                default:
                begin
                    r0 = idle_res;
                    n = idle_emit ? 2'd1 : 2'd0;
                    mode_next = idle_mode;
                    bad_next  = bad_reg | idle_bad;
                    if (idle_qs)
                    begin
                        qs_next = pos_reg;
                    end
                end
            endcase
        end

        // Mark the final result of this item.
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
        else if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
    end

    assign wr.count  = step ? n : 2'd0;
    assign wr.first  = r0;
    assign wr.second = r1;

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            qs_reg   <= '0;
            bad_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            qs_reg   <= qs_next;
            bad_reg  <= bad_next;
        end
    end

    // An end-of-line item returns the scanner to its starting state.
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.operation) |=> (mode_reg == MODE_IDLE && pos_reg == '0 && !bad_reg))
        else $error("scanner state not cleared after end of line");

    // The opening quote never lies beyond the current position.
    a_quote_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_QUOTE) |-> (qs_reg <= pos_reg))
        else $error("quote start lies beyond byte position");

    // The position never passes its saturation limit.
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position beyond its limit");

endmodule

FILE: rtl/sclt_out_fifo.sv
// ============================================================================
// sclt_out_fifo
// Small result queue. Takes up to two result items per cycle from the
// scanner and presents one per cycle on the output channel while tok_stall is low.
// ============================================================================
module sclt_out_fifo
    import sclt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lex_wr_t   wr,
    output logic      room,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok
);

    tok_item_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd;

    // Room for a full pair of results, judged from registered state only.
    assign room      = cnt_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign tok_valid = cnt_reg != '0;
    assign tok       = mem_reg[rd_ptr_reg];
    assign rd        = tok_valid && !tok_stall;
    assign cnt_next  = cnt_reg + CNT_W'(wr.count) - CNT_W'(rd);

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr.first;
        end
        if (wr.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= wr.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(wr.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(rd);
            cnt_reg    <= cnt_next;
        end
    end

    // Writes never exceed the free space.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(wr.count) <= (CNT_W + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // The fill count matches the pointer distance.
    a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != CNT_W'(FIFO_DEPTH)) |->
        (PTR_W'(cnt_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count and pointers disagree");

    // Nothing is written unless room was signalled.
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.count != 2'd0) |-> room)
        else $error("queue written without room");

endmodule

FILE: rtl/shell_command_line_tokenizer_unit.sv
// ============================================================================
// shell_command_line_tokenizer_unit
// Streaming command-line tokeniser: input register, scanner and result queue.
// ============================================================================
// An accepted item passes through the input register and then the result
// queue before its first result appears on tok. One input item is taken per
// cycle while cmd_stall is low; an item that causes two results presents
// them on tok one after the other, and the four-entry result queue sets how
// far the input may run ahead. Reset (rst_n low, asynchronous) empties the
// input register and the queue and puts the scanner between tokens at zero.
module shell_command_line_tokenizer_unit
    import sclt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok
);

    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      room;
    logic      step;
    lex_wr_t   wr;

    // The held item moves on whenever the queue can take a full pair.
    assign step      = in_valid_reg && room;
    assign cmd_stall = in_valid_reg && !room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall)
        begin
            in_item_reg <= cmd;
        end
    end

    sclt_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .wr    (wr)
    );

    sclt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

endmodule
